// ----- rtl/tx5551_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tx5551_pkg
// Shared types, codes and helper functions for the texel to RGBA5551 converter.
// ----------------------------------------------------------------------------
package tx5551_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;
  localparam int unsigned DimW     = 11;
  localparam int unsigned AddrW    = 20;

  typedef enum logic [2:0] {
    FMT_I4     = 3'd0,
    FMT_IA4    = 3'd1,
    FMT_I8     = 3'd2,
    FMT_IA8    = 3'd3,
    FMT_RGBA16 = 3'd4,
    FMT_RGBA32 = 3'd5
  } fmt_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FORMAT = 2'd0,
    CFG_KEEP   = 2'd1,
    CFG_WIDTH  = 2'd2,
    CFG_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0]        texel;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        old_pixel;
  } in_item_t;

  typedef struct packed {
    logic [AddrW-1:0] pixel_address;
    logic [15:0]      first_pixel;
    logic             first_write;
    logic [15:0]      second_pixel;
    logic             second_write;
  } out_item_t;

  typedef struct packed {
    logic [15:0] first_pixel;
    logic        first_write;
    logic [15:0] second_pixel;
    logic        second_write;
  } pix_t;

  typedef struct packed {
    logic [2:0]      fmt;
    logic            keep;
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic             on_screen;
    logic [AddrW-1:0] addr;
  } clip_t;

  function automatic logic [15:0] spread4(logic [3:0] i);
    return {i, 1'b0, i, 1'b0, i, 1'b0, 1'b1};
  endfunction

  function automatic logic [15:0] spread5(logic [4:0] i);
    return {i, i, i, 1'b1};
  endfunction

endpackage

// ----- rtl/tx5551_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tx5551_cfg
// Configuration registers with screen size saturation.
// ----------------------------------------------------------------------------
module tx5551_cfg #(
  parameter int MAX_SCREEN_DIM = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [tx5551_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [tx5551_pkg::CfgDataW-1:0]   cfg_data_i,
  output tx5551_pkg::cfg_t                  cfg_o
);

  logic [2:0]                  fmt_q;
  logic                        keep_q;
  logic [tx5551_pkg::DimW-1:0] width_q;
  logic [tx5551_pkg::DimW-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= 3'(tx5551_pkg::FMT_I4);
      keep_q   <= 1'b0;
      width_q  <= 11'd320;
      height_q <= 11'd240;
    end else if (cfg_valid_i) begin
      case (tx5551_pkg::cfg_idx_e'(cfg_index_i))
        tx5551_pkg::CFG_FORMAT: fmt_q    <= cfg_data_i[2:0];
        tx5551_pkg::CFG_KEEP:   keep_q   <= cfg_data_i[0];
        tx5551_pkg::CFG_WIDTH:  width_q  <= cfg_data_i[tx5551_pkg::DimW-1:0];
        tx5551_pkg::CFG_HEIGHT: height_q <= cfg_data_i[tx5551_pkg::DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.fmt    = fmt_q;
    cfg_o.keep   = keep_q;
    cfg_o.width  = (32'(width_q) > MAX_SCREEN_DIM) ? 11'(MAX_SCREEN_DIM) : width_q;
    cfg_o.height = (32'(height_q) > MAX_SCREEN_DIM) ? 11'(MAX_SCREEN_DIM) : height_q;
  end

endmodule

// ----- rtl/tx5551_clip.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tx5551_clip
// Screen clipping and linear framebuffer address.
// ----------------------------------------------------------------------------
module tx5551_clip (
  input  logic signed [15:0]          pos_x_i,
  input  logic signed [15:0]          pos_y_i,
  input  logic [tx5551_pkg::DimW-1:0] width_i,
  input  logic [tx5551_pkg::DimW-1:0] height_i,
  output tx5551_pkg::clip_t           clip_o
);

  logic                          x_in;
  logic                          y_in;
  logic [2*tx5551_pkg::DimW-1:0] row_base;
  logic [2*tx5551_pkg::DimW-1:0] lin;

  assign x_in = !pos_x_i[15] && (pos_x_i[14:0] < 15'(width_i));
  assign y_in = !pos_y_i[15] && (pos_y_i[14:0] < 15'(height_i));

  assign row_base = 22'(pos_y_i[tx5551_pkg::DimW-1:0]) * 22'(width_i);
  assign lin      = row_base + 22'(pos_x_i[tx5551_pkg::DimW-1:0]);

  always_comb begin
    clip_o.on_screen = x_in && y_in;
    clip_o.addr      = clip_o.on_screen ? lin[tx5551_pkg::AddrW-1:0] : '0;
  end

endmodule

// ----- rtl/tx5551_conv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tx5551_conv
// Texel format decode to RGBA5551, transparency handling and RGBA32 blend.
// ----------------------------------------------------------------------------
module tx5551_conv (
  input  logic [31:0]       texel_i,
  input  logic [15:0]       old_pixel_i,
  input  logic [2:0]        fmt_i,
  input  logic              keep_i,
  output tx5551_pkg::pix_t  pix_o
);

  // x / 255 as (x + (x >> 8) + 1) >> 8, exact over the blend range
  function automatic logic [4:0] blend_ch(logic [7:0] t, logic [4:0] o, logic [7:0] a);
    logic [16:0] x;
    logic [16:0] q;
    x = 17'(t) * 17'(a) + 17'({o, 3'b000}) * 17'(8'd255 - a);
    q = (x + (x >> 8) + 17'd1) >> 8;
    return q[7:3];
  endfunction

  logic [7:0]  tex_byte;
  logic [3:0]  hi_nib;
  logic [3:0]  lo_nib;
  logic [7:0]  alpha;
  logic [15:0] blend_val;
  logic [15:0] val1;
  logic [15:0] tval1;
  logic [15:0] val2;
  logic        opq1;
  logic        opq2;
  logic        use1;
  logic        use2;

  assign tex_byte = texel_i[7:0];
  assign hi_nib   = tex_byte[7:4];
  assign lo_nib   = tex_byte[3:0];
  assign alpha    = texel_i[7:0];

  assign blend_val = {blend_ch(texel_i[31:24], old_pixel_i[15:11], alpha),
                      blend_ch(texel_i[23:16], old_pixel_i[10:6], alpha),
                      blend_ch(texel_i[15:8], old_pixel_i[5:1], alpha),
                      1'b1};

  always_comb begin
    val1  = '0;
    tval1 = 16'd1;
    val2  = '0;
    opq1  = 1'b0;
    opq2  = 1'b0;
    use1  = 1'b0;
    use2  = 1'b0;
    case (fmt_i)
      3'(tx5551_pkg::FMT_I4): begin
        use1 = 1'b1;
        use2 = 1'b1;
        opq1 = hi_nib != 4'd0;
        opq2 = lo_nib != 4'd0;
        val1 = tx5551_pkg::spread4(hi_nib);
        val2 = tx5551_pkg::spread4(lo_nib);
      end
      3'(tx5551_pkg::FMT_IA4): begin
        use1 = 1'b1;
        use2 = 1'b1;
        opq1 = hi_nib[0];
        opq2 = lo_nib[0];
        val1 = tx5551_pkg::spread4(hi_nib & 4'hE);
        val2 = tx5551_pkg::spread4(lo_nib & 4'hE);
      end
      3'(tx5551_pkg::FMT_I8): begin
        use1 = 1'b1;
        opq1 = tex_byte[7:3] != 5'd0;
        val1 = tx5551_pkg::spread5(tex_byte[7:3]);
      end
      3'(tx5551_pkg::FMT_IA8): begin
        use1 = 1'b1;
        opq1 = lo_nib != 4'd0;
        val1 = tx5551_pkg::spread4(hi_nib);
      end
      3'(tx5551_pkg::FMT_RGBA16): begin
        use1  = 1'b1;
        opq1  = texel_i[0];
        val1  = texel_i[15:0];
        tval1 = texel_i[15:0] | 16'd1;
      end
      3'(tx5551_pkg::FMT_RGBA32): begin
        use1 = 1'b1;
        opq1 = alpha != 8'd0;
        val1 = blend_val;
      end
      default: ;
    endcase
  end

  always_comb begin
    pix_o = '0;
    if (use1) begin
      if (opq1) begin
        pix_o.first_pixel = val1;
        pix_o.first_write = 1'b1;
      end else if (!keep_i) begin
        pix_o.first_pixel = tval1;
        pix_o.first_write = 1'b1;
      end
    end
    if (use2) begin
      if (opq2) begin
        pix_o.second_pixel = val2;
        pix_o.second_write = 1'b1;
      end else if (!keep_i) begin
        pix_o.second_pixel = 16'd1;
        pix_o.second_write = 1'b1;
      end
    end
  end

endmodule

// ----- rtl/texel_to_rgba5551_clip_blend.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texel_to_rgba5551_clip_blend
// Texel to RGBA5551 conversion with framebuffer clipping and RGBA32 blending.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one texel item with its screen
// position and the framebuffer pixel now at that position. Output channel:
// out_valid_o / out_stall_i carry one result item per input item, holding the
// linear address and up to two pixel writes.
// An item is registered at the input, converted and clipped in one pass of
// logic, and registered at the output, which drives out_valid_o; one item is
// taken every cycle while the receiver does not stall.
// When the receiver stalls, the output register holds its item and the input
// register can still take one more item; only with both full is in_stall_o
// raised.
// The configuration channel (cfg_valid_i / cfg_ready_o) is always ready; the
// user must write it only while the block is idle; nothing here enforces it.
// Reset empties both stages and loads format i4, transparent write enabled,
// a 320 by 240 screen.
// ----------------------------------------------------------------------------
module texel_to_rgba5551_clip_blend #(
  parameter int MAX_SCREEN_DIM = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  tx5551_pkg::in_item_t            in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output tx5551_pkg::out_item_t           out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tx5551_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tx5551_pkg::CfgDataW-1:0] cfg_data_i
);

  tx5551_pkg::cfg_t      cfg;
  tx5551_pkg::pix_t      pix;
  tx5551_pkg::clip_t     clip;
  tx5551_pkg::in_item_t  in_q;
  tx5551_pkg::out_item_t out_d;
  tx5551_pkg::out_item_t out_q;
  logic                  in_valid_q;
  logic                  out_valid_q;
  logic                  out_load;
  logic                  in_load;

  assign cfg_ready_o = 1'b1;

  tx5551_cfg #(
    .MAX_SCREEN_DIM(MAX_SCREEN_DIM)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign out_load   = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign in_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load || out_load) begin
      in_valid_q <= in_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_q <= in_data_i;
    end
  end

  tx5551_conv u_conv (
    .texel_i    (in_q.texel),
    .old_pixel_i(in_q.old_pixel),
    .fmt_i      (cfg.fmt),
    .keep_i     (cfg.keep),
    .pix_o      (pix)
  );

  tx5551_clip u_clip (
    .pos_x_i (in_q.pos_x),
    .pos_y_i (in_q.pos_y),
    .width_i (cfg.width),
    .height_i(cfg.height),
    .clip_o  (clip)
  );

  always_comb begin
    out_d               = '0;
    out_d.pixel_address = clip.addr;
    if (clip.on_screen) begin
      out_d.first_pixel  = pix.first_pixel;
      out_d.first_write  = pix.first_write;
      out_d.second_pixel = pix.second_pixel;
      out_d.second_write = pix.second_write;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- verif/texel_to_rgba5551_clip_blend_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texel_to_rgba5551_clip_blend_test
// Self-checking bench for the texel to RGBA5551 converter with clipping.
// ----------------------------------------------------------------------------
// A short table of directed texels covers every format, transparency with and
// without keying, the screen edges, oversized and empty screens and the unused
// format codes. Random phases follow, each with its own register setting,
// sending mostly on-screen positions with random texels in bursts while the
// receiver stalls on changing patterns and once holds off long enough to fill
// the block. Results are checked against table entries or a pixel predictor.
// ----------------------------------------------------------------------------
module texel_to_rgba5551_clip_blend_test;

  localparam int          MAX_DIM     = 1024;
  localparam int          LIMIT       = 200000;
  localparam int          HOLD_CYCLES = 120;
  localparam int          PHASES      = 12;
  localparam int          PHASE_ITEMS = 84;
  localparam logic [2:0]  FMT_SPARE6  = 3'd6;
  localparam logic [2:0]  FMT_SPARE7  = 3'd7;

  typedef struct {
    logic [2:0]            fmt;
    logic                  keep;
    logic [10:0]           wid;
    logic [10:0]           hgt;
    tx5551_pkg::in_item_t  item;
    bit                    typed;
    tx5551_pkg::out_item_t want;
  } texel_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_n       = 1'b0;
  logic      in_valid    = 1'b0;
  tx5551_pkg::in_item_t in_data = '0;
  logic      out_stall   = 1'b0;
  logic      cfg_valid   = 1'b0;
  logic [tx5551_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [tx5551_pkg::CfgDataW-1:0] cfg_data  = '0;
  logic      in_stall;
  logic      out_valid;
  tx5551_pkg::out_item_t out_data;
  logic      cfg_ready;

  logic [2:0]  cur_fmt    = tx5551_pkg::FMT_I4;
  logic        cur_keep   = 1'b0;
  logic [10:0] cur_width  = 11'd320;
  logic [10:0] cur_height = 11'd240;

  tx5551_pkg::out_item_t pixel_writes_q[$];
  texel_row_t            texel_rows[$];
  tx5551_pkg::out_item_t head;
  int         n_err     = 0;
  int         n_sent    = 0;
  int         cycles    = 0;
  logic       hold_on   = 1'b0;
  int         stall_mode = 0;
  int         mode_left  = 0;
  bit         stall_pick;

  texel_to_rgba5551_clip_blend dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #2 clk_i = ~clk_i;

  function automatic int eff_dim(logic [10:0] d);
    return (d > MAX_DIM) ? MAX_DIM : int'(d);
  endfunction

  function automatic logic [15:0] fan4(logic [3:0] i);
    return {i, 1'b0, i, 1'b0, i, 1'b0, 1'b1};
  endfunction

  function automatic int unsigned blend8(logic [7:0] t, logic [4:0] o, logic [7:0] a);
    return (int'(t) * int'(a) + int'(o) * 8 * (255 - int'(a))) / 255;
  endfunction

  // {pixel, write} for one texel given its opacity
  function automatic logic [16:0] texel_write(bit opaque, logic [15:0] val,
                                              logic [15:0] tval);
    if (opaque) return {val, 1'b1};
    if (!cur_keep) return {tval, 1'b1};
    return '0;
  endfunction

  function automatic tx5551_pkg::out_item_t predict_pixels(tx5551_pkg::in_item_t it);
    tx5551_pkg::out_item_t r;
    int          w, h, x, y;
    logic [7:0]  b;
    logic [16:0] e1, e2;
    int unsigned rc, gc, bc;
    r  = '0;
    e1 = '0;
    e2 = '0;
    w  = eff_dim(cur_width);
    h  = eff_dim(cur_height);
    x  = int'($signed(it.pos_x));
    y  = int'($signed(it.pos_y));
    b  = it.texel[7:0];
    if (x >= 0 && x < w && y >= 0 && y < h) begin
      r.pixel_address = tx5551_pkg::AddrW'(x + y * w);
      case (cur_fmt)
        tx5551_pkg::FMT_I4: begin
          e1 = texel_write(b[7:4] != 0, fan4(b[7:4]), 16'h1);
          e2 = texel_write(b[3:0] != 0, fan4(b[3:0]), 16'h1);
        end
        tx5551_pkg::FMT_IA4: begin
          e1 = texel_write(b[4], fan4({b[7:5], 1'b0}), 16'h1);
          e2 = texel_write(b[0], fan4({b[3:1], 1'b0}), 16'h1);
        end
        tx5551_pkg::FMT_I8: begin
          e1 = texel_write(b[7:3] != 0, {b[7:3], b[7:3], b[7:3], 1'b1}, 16'h1);
        end
        tx5551_pkg::FMT_IA8: begin
          e1 = texel_write(b[3:0] != 0, fan4(b[7:4]), 16'h1);
        end
        tx5551_pkg::FMT_RGBA16: begin
          e1 = texel_write(it.texel[0], it.texel[15:0], it.texel[15:0] | 16'h1);
        end
        tx5551_pkg::FMT_RGBA32: begin
          rc = blend8(it.texel[31:24], it.old_pixel[15:11], b);
          gc = blend8(it.texel[23:16], it.old_pixel[10:6], b);
          bc = blend8(it.texel[15:8], it.old_pixel[5:1], b);
          e1 = texel_write(b != 0, {rc[7:3], gc[7:3], bc[7:3], 1'b1}, 16'h1);
        end
        default: begin
        end
      endcase
      {r.first_pixel, r.first_write}   = e1;
      {r.second_pixel, r.second_write} = e2;
    end
    return r;
  endfunction

  function automatic logic [15:0] random_coord(int dim);
    int c;
    c = $urandom_range(0, 9);
    if (c < 7 && dim > 0) return 16'($urandom_range(0, dim - 1));
    if (c == 7) begin
      case ($urandom_range(0, 3))
        0: return 16'hFFFF;
        1: return 16'(dim);
        2: return 16'(dim - 1);
        default: return 16'h0;
      endcase
    end
    return 16'($urandom);
  endfunction

  function automatic tx5551_pkg::in_item_t random_texel_item();
    tx5551_pkg::in_item_t it;
    int                   c;
    it.texel     = $urandom;
    it.pos_x     = random_coord(eff_dim(cur_width));
    it.pos_y     = random_coord(eff_dim(cur_height));
    it.old_pixel = 16'($urandom);
    c = $urandom_range(0, 7);
    if (c == 0) it.texel[7:0] = 8'h00;
    else if (c == 1) it.texel[7:0] = 8'hFF;
    return it;
  endfunction

  task automatic add_row(logic [2:0] fmt, logic keep, logic [10:0] wid,
                         logic [10:0] hgt, logic [31:0] texel, logic [15:0] x,
                         logic [15:0] y, logic [15:0] old, bit typed,
                         tx5551_pkg::out_item_t want);
    texel_row_t r;
    r.fmt  = fmt;
    r.keep = keep;
    r.wid  = wid;
    r.hgt  = hgt;
    r.item = '{texel: texel, pos_x: x, pos_y: y, old_pixel: old};
    r.typed = typed;
    r.want  = want;
    texel_rows.push_back(r);
  endtask

  task automatic send_item(tx5551_pkg::in_item_t it, tx5551_pkg::out_item_t want);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (in_stall);
    pixel_writes_q.push_back(want);
    n_sent++;
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pixel_writes_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(tx5551_pkg::cfg_idx_e idx,
                           logic [tx5551_pkg::CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic set_mode(logic [2:0] fmt, logic keep, logic [10:0] wid,
                          logic [10:0] hgt);
    drain();
    write_reg(tx5551_pkg::CFG_FORMAT, tx5551_pkg::CfgDataW'(fmt));
    cur_fmt = fmt;
    write_reg(tx5551_pkg::CFG_KEEP, tx5551_pkg::CfgDataW'(keep));
    cur_keep = keep;
    write_reg(tx5551_pkg::CFG_WIDTH, wid);
    cur_width = wid;
    write_reg(tx5551_pkg::CFG_HEIGHT, hgt);
    cur_height = hgt;
    cfg_valid <= 1'b0;
  endtask

  // receiver stall patterns, plus one long hold-off
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(16, 128);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: stall_pick = 1'b0;
      1: stall_pick = ($urandom_range(0, 3) == 0);
      2: stall_pick = ($urandom_range(0, 9) < 7);
      default: stall_pick = (cycles % 4 == 3);
    endcase
    out_stall <= hold_on || stall_pick;
  end

  initial begin
    wait (n_sent >= 400);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_writes_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected item: %p", out_data);
      end else begin
        head = pixel_writes_q.pop_front();
        if (head.pixel_address !== out_data.pixel_address ||
            head.first_pixel   !== out_data.first_pixel ||
            head.first_write   !== out_data.first_write ||
            head.second_pixel  !== out_data.second_pixel ||
            head.second_write  !== out_data.second_write) begin
          n_err++;
          if (n_err <= 10) $display("mismatch: expected %p, got %p", head, out_data);
        end
      end
    end
  end

  initial begin
    tx5551_pkg::in_item_t it;
    logic [2:0] fmt;
    logic [10:0] wid, hgt;
    int         burst_left;

    // directed texels: format, keying, screen, texel, x, y, old pixel
    add_row(tx5551_pkg::FMT_I4, 0, 320, 240,
            32'h0000_00F1, 16'd0, 16'd0, 16'h0, 1,
            {20'h0, 16'hF7BD, 1'b1, 16'h1085, 1'b1});
    add_row(tx5551_pkg::FMT_I4, 0, 320, 240,
            32'hFFFF_FF00, 16'd319, 16'd239, 16'hFFFF, 1,
            {20'h12BFF, 16'h0001, 1'b1, 16'h0001, 1'b1});
    add_row(tx5551_pkg::FMT_I4, 0, 320, 240,
            32'h0000_00FF, 16'hFFFF, 16'd0, 16'h0, 1, '0);
    add_row(tx5551_pkg::FMT_I4, 0, 320, 240,
            32'h0000_00FF, 16'd320, 16'd0, 16'h0, 1, '0);
    add_row(tx5551_pkg::FMT_I4, 0, 320, 240,
            32'h0000_00FF, 16'd0, 16'd240, 16'h0, 1, '0);
    add_row(tx5551_pkg::FMT_I4, 0, 320, 240,
            32'h0000_00FF, 16'h7FFF, 16'h8000, 16'h0, 1, '0);
    add_row(tx5551_pkg::FMT_I4, 1, 320, 240,
            32'h0000_000F, 16'd5, 16'd7, 16'h0, 0, '0);
    add_row(tx5551_pkg::FMT_IA4, 0, 320, 240,
            32'h0000_00A5, 16'd10, 16'd10, 16'h0, 0, '0);
    add_row(tx5551_pkg::FMT_IA4, 1, 320, 240,
            32'h0000_00FE, 16'd11, 16'd10, 16'h0, 0, '0);
    add_row(tx5551_pkg::FMT_I8, 0, 320, 240,
            32'h0000_00FF, 16'd0, 16'd0, 16'h0, 1,
            {20'h0, 16'hFFFF, 1'b1, 16'h0, 1'b0});
    add_row(tx5551_pkg::FMT_I8, 0, 320, 240,
            32'hFFFF_FF07, 16'd1, 16'd0, 16'h0, 1,
            {20'h1, 16'h0001, 1'b1, 16'h0, 1'b0});
    add_row(tx5551_pkg::FMT_IA8, 0, 320, 240,
            32'h0000_00F0, 16'd2, 16'd0, 16'h0, 1,
            {20'h2, 16'h0001, 1'b1, 16'h0, 1'b0});
    add_row(tx5551_pkg::FMT_IA8, 1, 320, 240,
            32'h0000_005A, 16'd3, 16'd3, 16'h0, 0, '0);
    add_row(tx5551_pkg::FMT_RGBA16, 0, 320, 240,
            32'h0000_1234, 16'd4, 16'd0, 16'h0, 1,
            {20'h4, 16'h1235, 1'b1, 16'h0, 1'b0});
    add_row(tx5551_pkg::FMT_RGBA16, 1, 320, 240,
            32'h0000_1234, 16'd4, 16'd0, 16'h0, 1,
            {20'h4, 16'h0, 1'b0, 16'h0, 1'b0});
    add_row(tx5551_pkg::FMT_RGBA32, 0, 320, 240,
            32'hFFFF_FFFF, 16'd0, 16'd1, 16'h0, 1,
            {20'd320, 16'hFFFF, 1'b1, 16'h0, 1'b0});
    add_row(tx5551_pkg::FMT_RGBA32, 0, 320, 240,
            32'hFFFF_FF00, 16'd1, 16'd1, 16'h0, 1,
            {20'd321, 16'h0001, 1'b1, 16'h0, 1'b0});
    add_row(tx5551_pkg::FMT_RGBA32, 1, 320, 240,
            32'h1234_5600, 16'd1, 16'd1, 16'h0, 1,
            {20'd321, 16'h0, 1'b0, 16'h0, 1'b0});
    add_row(tx5551_pkg::FMT_RGBA32, 0, 320, 240,
            32'h80C0_4080, 16'd9, 16'd9, 16'hA5A5, 0, '0);
    add_row(FMT_SPARE6, 0, 320, 240,
            32'h0000_FFFF, 16'd7, 16'd0, 16'h0, 1,
            {20'd7, 16'h0, 1'b0, 16'h0, 1'b0});
    add_row(FMT_SPARE7, 0, 320, 240,
            32'h0000_FFFF, 16'd7, 16'd0, 16'h0, 1,
            {20'd7, 16'h0, 1'b0, 16'h0, 1'b0});
    add_row(tx5551_pkg::FMT_RGBA16, 0, 1024, 1024,
            32'h0000_FFFF, 16'd1023, 16'd1023, 16'h0, 1,
            {20'hFFFFF, 16'hFFFF, 1'b1, 16'h0, 1'b0});
    add_row(tx5551_pkg::FMT_RGBA16, 0, 2047, 2047,
            32'h0000_FFFF, 16'd1024, 16'd0, 16'h0, 1, '0);
    add_row(tx5551_pkg::FMT_RGBA16, 0, 2047, 2047,
            32'h0000_FFFF, 16'd1023, 16'd1023, 16'h0, 1,
            {20'hFFFFF, 16'hFFFF, 1'b1, 16'h0, 1'b0});
    add_row(tx5551_pkg::FMT_I4, 0, 0, 240,
            32'h0000_0011, 16'd0, 16'd0, 16'h0, 1, '0);
    add_row(tx5551_pkg::FMT_I4, 0, 1, 0,
            32'h0000_0011, 16'd0, 16'd0, 16'h0, 1, '0);
    add_row(tx5551_pkg::FMT_I4, 0, 1, 1,
            32'h0000_0012, 16'd0, 16'd0, 16'h0, 0, '0);

    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    foreach (texel_rows[i]) begin
      if (texel_rows[i].fmt != cur_fmt || texel_rows[i].keep != cur_keep ||
          texel_rows[i].wid != cur_width || texel_rows[i].hgt != cur_height) begin
        set_mode(texel_rows[i].fmt, texel_rows[i].keep, texel_rows[i].wid,
                 texel_rows[i].hgt);
      end
      send_item(texel_rows[i].item, texel_rows[i].typed ? texel_rows[i].want
                                                        : predict_pixels(texel_rows[i].item));
    end

    burst_left = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      fmt = (ph < 6) ? 3'(ph) : 3'($urandom_range(0, 7));
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: wid = 11'($urandom_range(1, 64));
        5: wid = 11'd320;
        6: wid = 11'd1024;
        7: wid = 11'($urandom_range(1025, 2047));
        default: wid = 11'($urandom_range(1, 1024));
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: hgt = 11'($urandom_range(1, 64));
        5: hgt = 11'd240;
        6: hgt = 11'd1024;
        7: hgt = 11'($urandom_range(1025, 2047));
        default: hgt = 11'($urandom_range(1, 1024));
      endcase
      if (ph == 0) begin
        wid = 11'd1;
        hgt = 11'd1;
      end else if (ph == 1) begin
        wid = 11'd1024;
        hgt = 11'd1024;
      end
      set_mode(fmt, 1'($urandom_range(0, 1)), wid, hgt);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          if (!hold_on && $urandom_range(0, 2) != 0) pause($urandom_range(1, 8));
        end
        burst_left--;
        it = random_texel_item();
        send_item(it, predict_pixels(it));
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (n_err == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
